// ===== rtl/tnbc_pkg.sv =====
package tnbc_pkg;

  localparam int unsigned NBR_COUNT = 8;
  localparam int unsigned CODE_W    = 8;

  localparam logic [1:0] KIND_FULL     = 2'd0;
  localparam logic [1:0] KIND_STRAIGHT = 2'd1;
  localparam logic [1:0] KIND_CORNER   = 2'd2;
  localparam logic [1:0] KIND_BEND     = 2'd3;

  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_AXIS_CNT  = 2'd1;
  localparam logic [1:0] ERR_DIAG_CNT  = 2'd2;
  localparam logic [1:0] ERR_NO_DIR    = 2'd3;

  localparam logic [4:0] UV_NORTH = 5'd24;
  localparam logic [4:0] UV_EAST  = 5'd20;
  localparam logic [4:0] UV_SOUTH = 5'd16;
  localparam logic [4:0] UV_WEST  = 5'd28;

  typedef struct packed {
    logic [7:0]  center_terrain;
    logic [63:0] neighbour_terrains;
    logic [7:0]  neighbour_on_map;
    logic [1:0]  random_direction;
  } in_item_t;

  typedef struct packed {
    logic       orphan;
    logic [1:0] blend_kind;
    logic [1:0] direction;
    logic [4:0] uv_rotation;
    logic [1:0] error_code;
  } out_item_t;

  // table lookup result: valid flag plus direction
  typedef struct packed {
    logic       hit;
    logic [1:0] dir;
  } dir_lkp_t;

  function automatic logic [4:0] uv_of_dir(input logic [1:0] dir);
    logic [4:0] uv;
    unique case (dir)
      DIR_NORTH: uv = UV_NORTH;
      DIR_EAST:  uv = UV_EAST;
      DIR_SOUTH: uv = UV_SOUTH;
      DIR_WEST:  uv = UV_WEST;
      default:   uv = UV_NORTH;
    endcase
    return uv;
  endfunction

  function automatic dir_lkp_t straight_dir(input logic [3:0] mask);
    dir_lkp_t r;
    r = '{hit: 1'b1, dir: DIR_NORTH};
    case (mask)
      4'd7:    r.dir = DIR_WEST;
      4'd11:   r.dir = DIR_NORTH;
      4'd13:   r.dir = DIR_EAST;
      4'd14:   r.dir = DIR_SOUTH;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic dir_lkp_t corner_dir(input logic [3:0] mask);
    dir_lkp_t r;
    r = '{hit: 1'b1, dir: DIR_NORTH};
    case (mask)
      4'd3:    r.dir = DIR_WEST;
      4'd6:    r.dir = DIR_SOUTH;
      4'd9:    r.dir = DIR_NORTH;
      4'd12:   r.dir = DIR_EAST;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic dir_lkp_t bend_dir(input logic [3:0] mask);
    dir_lkp_t r;
    r = '{hit: 1'b1, dir: DIR_NORTH};
    case (mask)
      4'd7:    r.dir = DIR_SOUTH;
      4'd11:   r.dir = DIR_WEST;
      4'd13:   r.dir = DIR_NORTH;
      4'd14:   r.dir = DIR_EAST;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] popcnt4(input logic [3:0] v);
    return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
  endfunction

endpackage

// ===== rtl/tnbc_classify.sv =====
module tnbc_classify (
  input  tnbc_pkg::in_item_t  item,
  output tnbc_pkg::out_item_t result
);

  logic [7:0]  match;
  logic [3:0]  seg;
  logic [7:0]  run_hit;
  logic [3:0]  axis;
  logic [3:0]  diag;
  logic [2:0]  na;
  logic [2:0]  nd;
  logic        orphan;
  logic [1:0]  kind;
  logic [1:0]  dir;
  logic [1:0]  err;
  tnbc_pkg::dir_lkp_t lkp_s;
  tnbc_pkg::dir_lkp_t lkp_c;
  tnbc_pkg::dir_lkp_t lkp_b;

  // off-map or same terrain counts as a match
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      match[i] = !item.neighbour_on_map[i] ||
                 (item.neighbour_terrains[8*i +: 8] == item.center_terrain);
    end
  end

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      seg[s]  = match[2*s] & match[2*s+1] & match[(2*s+2) % 8];
      axis[s] = match[2*s];
      diag[s] = match[2*s+1];
    end
    // differ, match, match, differ at any rotation of the ring
    for (int i = 0; i < 8; i++) begin
      run_hit[i] = !match[i] & match[(i+7) % 8] & match[(i+6) % 8] & !match[(i+5) % 8];
    end
  end

  assign na    = tnbc_pkg::popcnt4(axis);
  assign nd    = tnbc_pkg::popcnt4(diag);
  assign lkp_s = tnbc_pkg::straight_dir(axis);
  assign lkp_c = tnbc_pkg::corner_dir(axis);
  assign lkp_b = tnbc_pkg::bend_dir(diag);

  always_comb begin
    orphan = 1'b0;
    kind   = tnbc_pkg::KIND_FULL;
    dir    = item.random_direction;
    err    = tnbc_pkg::ERR_OK;
    if (item.center_terrain != '0) begin
      orphan = (seg == 4'd0) || (seg == 4'd5) || (seg == 4'd10) || (|run_hit);
      if (na == 3'd2) begin
        kind = tnbc_pkg::KIND_CORNER;
        dir  = lkp_c.dir;
        if (!lkp_c.hit) err = tnbc_pkg::ERR_NO_DIR;
      end else if (na == 3'd3) begin
        kind = tnbc_pkg::KIND_STRAIGHT;
        dir  = lkp_s.dir;
        if (!lkp_s.hit) err = tnbc_pkg::ERR_NO_DIR;
      end else if (na == 3'd4) begin
        if (nd == 3'd4) begin
          kind = tnbc_pkg::KIND_FULL;
        end else if (nd == 3'd3) begin
          kind = tnbc_pkg::KIND_BEND;
          dir  = lkp_b.dir;
          if (!lkp_b.hit) err = tnbc_pkg::ERR_NO_DIR;
        end else begin
          err = tnbc_pkg::ERR_DIAG_CNT;
        end
      end else begin
        err = tnbc_pkg::ERR_AXIS_CNT;
      end
    end
  end

  always_comb begin
    result.orphan     = orphan;
    result.error_code = err;
    if (err != tnbc_pkg::ERR_OK) begin
      result.blend_kind  = tnbc_pkg::KIND_FULL;
      result.direction   = tnbc_pkg::DIR_NORTH;
      result.uv_rotation = '0;
    end else begin
      result.blend_kind  = kind;
      result.direction   = dir;
      result.uv_rotation = tnbc_pkg::uv_of_dir(dir);
    end
  end

endmodule

// ===== rtl/tile_neighbourhood_blend_classifier_unit.sv =====
// Tile neighbourhood blend classifier.
// Input channel in_valid/in_ready/in_data carries one cell per request:
// centre terrain, eight neighbour codes (N clockwise), on-map mask and a
// random direction. Output channel out_valid/out_ready/out_data returns the
// orphan flag, blend kind, direction, UV rotation code and error code.
// One result per request, in order.
// out_valid rises once a request has passed the input register, then the
// result register, with the classifier logic between them.
// Throughput: one request per cycle while out_ready is high, as each
// needs a single classifier pass; the registers form a two-entry pipeline.
// A stalled receiver holds the result register; the input register keeps
// accepting until it too is full, then in_ready drops. in_ready follows
// out_ready combinationally.
// Reset (rst_n low, synchronous) empties both stages; only the pipeline
// valid flags are reset, not the data registers.
module tile_neighbourhood_blend_classifier_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tnbc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tnbc_pkg::out_item_t out_data
);

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  tnbc_pkg::in_item_t  s1_data_r;
  logic                s2_valid_r;
  logic                s2_valid_nxt;
  tnbc_pkg::out_item_t s2_data_r;
  tnbc_pkg::out_item_t cls_res;
  logic                s2_adv;
  logic                s1_load;

  tnbc_classify u_classify (
    .item   (s1_data_r),
    .result (cls_res)
  );

  assign s2_adv   = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_adv;
  assign s1_load  = in_valid && in_ready;

  assign s1_valid_nxt = s1_load ? 1'b1 : (s2_adv ? 1'b0 : s1_valid_r);
  assign s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
    if (s2_adv && s1_valid_r) begin
      s2_data_r <= cls_res;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

  a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error_code != tnbc_pkg::ERR_OK) |->
      (out_data.blend_kind == tnbc_pkg::KIND_FULL) &&
      (out_data.direction == tnbc_pkg::DIR_NORTH) && (out_data.uv_rotation == '0))
    else $error("error result with non-zero blend fields");

  a_uv_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error_code == tnbc_pkg::ERR_OK) |->
      out_data.uv_rotation == tnbc_pkg::uv_of_dir(out_data.direction))
    else $error("uv rotation does not follow direction");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("input stage lost a request while stalled");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("empty input stage refused a request");

  a_base_not_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_data_r.center_terrain == '0) |-> !cls_res.orphan)
    else $error("base terrain flagged as orphan");

endmodule

// ===== bench/tile_neighbourhood_blend_classifier_unit_tb.sv =====
`timescale 1ns / 100ps

module tile_neighbourhood_blend_classifier_unit_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int RANDOM_CELLS = 400;

  class cell_blend_board;
    localparam logic [2:0] NO_DIR = 3'd4;

    tnbc_pkg::out_item_t expected_blends[$];
    int unsigned mismatches = 0;

    static function tnbc_pkg::out_item_t classify_cell(tnbc_pkg::in_item_t c);
      tnbc_pkg::out_item_t r;
      logic [7:0] m;
      logic [3:0] axis, diag, seg, run;
      logic [2:0] d;
      int na, nd;
      r = '0;
      r.error_code = tnbc_pkg::ERR_OK;
      if (c.center_terrain == 8'd0) begin
        r.blend_kind = tnbc_pkg::KIND_FULL;
        d = {1'b0, c.random_direction};
      end else begin
        for (int i = 0; i < 8; i++)
          m[i] = !c.neighbour_on_map[i] || c.neighbour_terrains[8*i +: 8] == c.center_terrain;
        seg[0] = &m[2:0];
        seg[1] = &m[4:2];
        seg[2] = &m[6:4];
        seg[3] = m[6] & m[7] & m[0];
        r.orphan = seg == 4'd0 || seg == 4'd5 || seg == 4'd10;
        // differ, match, match, differ around the ring, wrapping past north
        run = 4'hF;
        for (int s = 0; s < 11; s++) begin
          run = run >> 1;
          if (m[s % 8]) run[3] = 1'b1;
          if (run == 4'd6) r.orphan = 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
          axis[k] = m[2*k];
          diag[k] = m[2*k+1];
        end
        na = $countones(axis);
        nd = $countones(diag);
        d = NO_DIR;
        case (na)
          2: begin
            r.blend_kind = tnbc_pkg::KIND_CORNER;
            case (axis)
              4'd3:  d = {1'b0, tnbc_pkg::DIR_WEST};
              4'd6:  d = {1'b0, tnbc_pkg::DIR_SOUTH};
              4'd9:  d = {1'b0, tnbc_pkg::DIR_NORTH};
              4'd12: d = {1'b0, tnbc_pkg::DIR_EAST};
              default: d = NO_DIR;
            endcase
          end
          3: begin
            r.blend_kind = tnbc_pkg::KIND_STRAIGHT;
            case (axis)
              4'd7:  d = {1'b0, tnbc_pkg::DIR_WEST};
              4'd11: d = {1'b0, tnbc_pkg::DIR_NORTH};
              4'd13: d = {1'b0, tnbc_pkg::DIR_EAST};
              4'd14: d = {1'b0, tnbc_pkg::DIR_SOUTH};
              default: d = NO_DIR;
            endcase
          end
          4: begin
            if (nd == 4) begin
              r.blend_kind = tnbc_pkg::KIND_FULL;
              d = {1'b0, c.random_direction};
            end else if (nd == 3) begin
              r.blend_kind = tnbc_pkg::KIND_BEND;
              case (diag)
                4'd7:  d = {1'b0, tnbc_pkg::DIR_SOUTH};
                4'd11: d = {1'b0, tnbc_pkg::DIR_WEST};
                4'd13: d = {1'b0, tnbc_pkg::DIR_NORTH};
                4'd14: d = {1'b0, tnbc_pkg::DIR_EAST};
                default: d = NO_DIR;
              endcase
            end else begin
              r.error_code = tnbc_pkg::ERR_DIAG_CNT;
            end
          end
          default: r.error_code = tnbc_pkg::ERR_AXIS_CNT;
        endcase
        if (r.error_code == tnbc_pkg::ERR_OK && d == NO_DIR)
          r.error_code = tnbc_pkg::ERR_NO_DIR;
      end
      if (r.error_code != tnbc_pkg::ERR_OK) begin
        r.blend_kind = tnbc_pkg::KIND_FULL;
        r.direction = tnbc_pkg::DIR_NORTH;
        r.uv_rotation = 5'd0;
      end else begin
        r.direction = d[1:0];
        case (d[1:0])
          tnbc_pkg::DIR_NORTH: r.uv_rotation = tnbc_pkg::UV_NORTH;
          tnbc_pkg::DIR_EAST:  r.uv_rotation = tnbc_pkg::UV_EAST;
          tnbc_pkg::DIR_SOUTH: r.uv_rotation = tnbc_pkg::UV_SOUTH;
          default:             r.uv_rotation = tnbc_pkg::UV_WEST;
        endcase
      end
      return r;
    endfunction

    function void note_cell(tnbc_pkg::in_item_t c);
      expected_blends.push_back(classify_cell(c));
    endfunction

    function int pending();
      return expected_blends.size();
    endfunction

    function void compare_field(string name, logic [4:0] exp_v, logic [4:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(tnbc_pkg::out_item_t got);
      tnbc_pkg::out_item_t exp_r;
      if (expected_blends.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        return;
      end
      exp_r = expected_blends.pop_front();
      compare_field("orphan", 5'(exp_r.orphan), 5'(got.orphan));
      compare_field("blend_kind", 5'(exp_r.blend_kind), 5'(got.blend_kind));
      compare_field("direction", 5'(exp_r.direction), 5'(got.direction));
      compare_field("uv_rotation", exp_r.uv_rotation, got.uv_rotation);
      compare_field("error_code", 5'(exp_r.error_code), 5'(got.error_code));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tnbc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tnbc_pkg::out_item_t out_data;

  cell_blend_board board = new();
  bit hold_off_req = 1'b0;
  int idle_cycles = 0;

  tile_neighbourhood_blend_classifier_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // neighbours flagged in mask match (off map or same code), the rest differ
  function automatic tnbc_pkg::in_item_t build_cell(logic [7:0] centre, logic [7:0] mask,
                                                    logic [1:0] rnd);
    tnbc_pkg::in_item_t c;
    c.center_terrain = centre;
    c.random_direction = rnd;
    for (int i = 0; i < 8; i++) begin
      if (mask[i] && $urandom_range(0, 1) == 0) begin
        c.neighbour_on_map[i] = 1'b0;
        c.neighbour_terrains[8*i +: 8] = 8'($urandom_range(0, 255));
      end else if (mask[i]) begin
        c.neighbour_on_map[i] = 1'b1;
        c.neighbour_terrains[8*i +: 8] = centre;
      end else begin
        c.neighbour_on_map[i] = 1'b1;
        c.neighbour_terrains[8*i +: 8] = centre ^ 8'($urandom_range(1, 255));
      end
    end
    return c;
  endfunction

  function automatic tnbc_pkg::in_item_t random_cell();
    tnbc_pkg::in_item_t c;
    logic [7:0] mask;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      c = build_cell(8'd0, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    end else if (sel < 20) begin
      c.center_terrain = 8'($urandom_range(0, 255));
      c.neighbour_terrains = {$urandom, $urandom};
      c.neighbour_on_map = 8'($urandom_range(0, 255));
      c.random_direction = 2'($urandom_range(0, 3));
    end else begin
      case ($urandom_range(0, 2))
        0: mask = 8'($urandom_range(0, 255));
        1: mask = 8'hFF ^ (8'd1 << $urandom_range(0, 7));
        default: mask = 8'hFF ^ (8'd1 << $urandom_range(0, 7)) ^ (8'd1 << $urandom_range(0, 7));
      endcase
      c = build_cell(8'($urandom_range(1, 255)), mask, 2'($urandom_range(0, 3)));
    end
    return c;
  endfunction

  task automatic send_cell(tnbc_pkg::in_item_t c);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    board.note_cell(c);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tile_neighbourhood_blend_classifier_unit_tb: errors");
      $finish;
    end
  end

  // receiver: stall patterns of its own, plus one long hold-off on request
  initial begin
    int mode;
    int len;
    int phase;
    phase = 0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(20, 80);
        for (int k = 0; k < len && !hold_off_req; k++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (phase % 3) == 0;
            default: out_ready <= $urandom_range(0, 3) != 0;
          endcase
          phase++;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [7:0] directed_masks [24];
    int burst_left;
    int gap;
    directed_masks = '{
      8'hFF, 8'hFF,
      8'hBF, 8'hEF, 8'hFB, 8'hFE,
      8'hAF, 8'hBE, 8'hEB, 8'hFA,
      8'hBB, 8'hEE,
      8'hFD, 8'hF7, 8'hDF, 8'h7F,
      8'h55, 8'hF5,
      8'h00, 8'h01, 8'hAA,
      8'h77, 8'hDD, 8'hF6
    };
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cell(build_cell(8'd0, 8'h00, tnbc_pkg::DIR_WEST));
    send_cell(build_cell(8'd0, 8'hFF, tnbc_pkg::DIR_EAST));
    foreach (directed_masks[i])
      send_cell(build_cell((i % 2) ? 8'hFF : 8'h01, directed_masks[i], 2'(i)));
    // wrap-around run across north
    send_cell(build_cell(8'h80, 8'hBD, tnbc_pkg::DIR_SOUTH));
    drain_requests();

    for (int n = 0; n < RANDOM_CELLS; n++) begin
      if (n == 260) begin
        drain_requests();
      end else if (n == 120) begin
        hold_off_req = 1'b1;
        burst_left = 16;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_cell(random_cell());
      burst_left--;
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0)
      $display("tile_neighbourhood_blend_classifier_unit_tb: clean");
    else
      $display("tile_neighbourhood_blend_classifier_unit_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tnbc_pkg.sv
rtl/tnbc_classify.sv
rtl/tile_neighbourhood_blend_classifier_unit.sv
bench/tile_neighbourhood_blend_classifier_unit_tb.sv
